@@ rtl/assert_macros.svh @@
// Assertion helpers used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Assert a named property that carries its own clocking.
`define APR_ASSERT(lbl, prop, msg) lbl: assert property (prop) else $error(msg);

// Assert an implication on the rising clock edge, disabled while reset is high.
`define APR_ASSERT_CLK(lbl, clk, rst, expr, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) expr) else $error(msg);

`endif

@@ rtl/apr_pkg.sv @@
// ---------------------------------------------------------------------------
// apr_pkg
// Types and constants shared by the pixel unpremultiply datapath.
// ---------------------------------------------------------------------------
package apr_pkg;

   localparam int CHAN_W      = 8;
   localparam int NUMER_W     = 16;
   localparam int RECIP_SHIFT = 17;
   localparam int RECIP_W     = RECIP_SHIFT + 1;
   localparam int NUM_LANES   = 3;
   localparam int LANE_STAGES = 3;
   localparam int PIPE_DEPTH  = LANE_STAGES + 1;

   // Lane order inside the datapath
   localparam int LANE_RED   = 0;
   localparam int LANE_GREEN = 1;
   localparam int LANE_BLUE  = 2;

   typedef logic [CHAN_W-1:0]  chan_type;
   typedef logic [NUMER_W-1:0] numer_type;
   typedef logic [RECIP_W-1:0] recip_type;

   localparam chan_type CHAN_MAX    = 8'hFF;
   localparam chan_type ALPHA_CLEAR = 8'h00;

   typedef struct packed {
      logic advance;
      logic bypass;
   } lane_ctl_type;

endpackage

@@ rtl/apr_if.sv @@
// ---------------------------------------------------------------------------
// apr_req_if / apr_rsp_if
// Valid/ready channels carrying one premultiplied and one straight pixel.
// ---------------------------------------------------------------------------
interface apr_req_if;
   logic              valid;
   logic              ready;
   apr_pkg::chan_type blue_in;
   apr_pkg::chan_type green_in;
   apr_pkg::chan_type red_in;
   apr_pkg::chan_type alpha_in;

   modport source (output valid, output blue_in, output green_in, output red_in,
                   output alpha_in, input ready);
   modport sink   (input valid, input blue_in, input green_in, input red_in,
                   input alpha_in, output ready);
endinterface

interface apr_rsp_if;
   logic              valid;
   logic              ready;
   apr_pkg::chan_type red_out;
   apr_pkg::chan_type green_out;
   apr_pkg::chan_type blue_out;
   apr_pkg::chan_type alpha_out;

   modport source (output valid, output red_out, output green_out, output blue_out,
                   output alpha_out, input ready);
   modport sink   (input valid, input red_out, input green_out, input blue_out,
                   input alpha_out, output ready);
endinterface

@@ rtl/apr_recip.sv @@
// ---------------------------------------------------------------------------
// apr_recip
// Reciprocal lookup: floor(2^RECIP_SHIFT / alpha), registered.
// ---------------------------------------------------------------------------
module apr_recip (
   input  logic                clock,
   input  logic                advance,
   input  apr_pkg::chan_type   alpha,
   output apr_pkg::recip_type  recip_ff
);

   localparam int Depth = 1 << apr_pkg::CHAN_W;

   apr_pkg::recip_type rom [Depth];

   for (genvar i = 0; i < Depth; i++) begin : g_rom
      // zero alpha is bypassed downstream, its entry only needs to be defined
      localparam int Divisor = (i == 0) ? 1 : i;
      localparam apr_pkg::recip_type Entry =
         apr_pkg::recip_type'((1 << apr_pkg::RECIP_SHIFT) / Divisor);
      assign rom[i] = Entry;
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         recip_ff <= rom[alpha];
      end
   end

endmodule

@@ rtl/apr_lane.sv @@
// ---------------------------------------------------------------------------
// apr_lane
// One color lane: rounded (c*255 + a/2) / a by reciprocal multiply,
// one-step correction, saturation and pass-through for clear/opaque alpha.
// ---------------------------------------------------------------------------
module apr_lane (
   input  logic                  clock,
   input  apr_pkg::lane_ctl_type ctl,
   input  apr_pkg::chan_type     chan,
   input  apr_pkg::chan_type     alpha,
   input  apr_pkg::recip_type    recip,
   output apr_pkg::chan_type     res_ff
);

   localparam int ProdW = apr_pkg::NUMER_W + apr_pkg::RECIP_W;
   localparam int BackW = apr_pkg::NUMER_W + apr_pkg::CHAN_W;
   localparam int QuotW = apr_pkg::NUMER_W + 1;

   // first stage: numerator
   apr_pkg::numer_type  numer_in;
   apr_pkg::numer_type  numer1_ff;
   apr_pkg::recip_type  recip1_ff;
   apr_pkg::chan_type   alpha1_ff;
   apr_pkg::chan_type   chan1_ff;
   logic                bypass1_ff;

   // second stage: quotient estimate
   logic [ProdW-1:0]    prod;
   apr_pkg::numer_type  est_in;
   apr_pkg::numer_type  est_ff;
   apr_pkg::numer_type  numer2_ff;
   apr_pkg::chan_type   alpha2_ff;
   apr_pkg::chan_type   chan2_ff;
   logic                bypass2_ff;

   // third stage: correction and saturation
   logic [BackW-1:0]    back;
   apr_pkg::numer_type  rem;
   logic                bump;
   logic [QuotW-1:0]    quot;
   apr_pkg::chan_type   res_in;

   // c*255 as (c<<8) - c, plus half the divisor for rounding
   assign numer_in = apr_pkg::numer_type'({chan, 8'h00})
                   - apr_pkg::numer_type'(chan)
                   + apr_pkg::numer_type'(alpha >> 1);

   always_ff @(posedge clock) begin
      if (ctl.advance) begin
         numer1_ff  <= numer_in;
         recip1_ff  <= recip;
         alpha1_ff  <= alpha;
         chan1_ff   <= chan;
         bypass1_ff <= ctl.bypass;
      end
   end

   // estimate is never above the true quotient and at most one below it
   assign prod   = ProdW'(numer1_ff) * ProdW'(recip1_ff);
   assign est_in = apr_pkg::numer_type'(prod >> apr_pkg::RECIP_SHIFT);

   always_ff @(posedge clock) begin
      if (ctl.advance) begin
         est_ff     <= est_in;
         numer2_ff  <= numer1_ff;
         alpha2_ff  <= alpha1_ff;
         chan2_ff   <= chan1_ff;
         bypass2_ff <= bypass1_ff;
      end
   end

   assign back = BackW'(est_ff) * BackW'(alpha2_ff);
   assign rem  = numer2_ff - apr_pkg::numer_type'(back);
   assign bump = (rem >= apr_pkg::numer_type'(alpha2_ff));
   assign quot = QuotW'(est_ff) + QuotW'(bump);

   always_comb begin
      priority if (bypass2_ff) begin
         res_in = chan2_ff;
      end else if (quot > QuotW'(apr_pkg::CHAN_MAX)) begin
         res_in = apr_pkg::CHAN_MAX;
      end else begin
         res_in = apr_pkg::chan_type'(quot);
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.advance) begin
         res_ff <= res_in;
      end
   end

endmodule

@@ rtl/argb_premultiplied_to_rgba.sv @@
// ---------------------------------------------------------------------------
// argb_premultiplied_to_rgba
// Path: input register, then the three lane stages; the last is the output register.
// Throughput: one word per cycle; the three color lanes and the reciprocal
// table are fully pipelined, rsp ready stalls every stage at once.
// Reset clears only the stage valid bits; data registers are not reset.
// ---------------------------------------------------------------------------
module argb_premultiplied_to_rgba (
   input  logic      clock,
   input  logic      reset,
   apr_req_if.sink   req_port,
   apr_rsp_if.source rsp_port
);

   // One valid bit per stage: input register, then the three lane stages.
   // The last lane stage is the output register.
   logic [apr_pkg::PIPE_DEPTH-1:0] vld_ff;
   logic [apr_pkg::PIPE_DEPTH-1:0] vld_in;
   logic                           advance;

   // input register, one entry per color lane
   apr_pkg::chan_type  chan0_ff [apr_pkg::NUM_LANES];
   apr_pkg::chan_type  alpha0_ff;
   apr_pkg::recip_type recip0_ff;

   // alpha rides alongside the lane stages
   apr_pkg::chan_type  alpha_dly_ff [apr_pkg::LANE_STAGES];

   apr_pkg::lane_ctl_type lane_ctl;
   apr_pkg::chan_type     lane_res [apr_pkg::NUM_LANES];

   // Advance the whole pipe whenever the output register is empty or drained.
   assign advance        = !vld_ff[apr_pkg::PIPE_DEPTH-1] || rsp_port.ready;
   assign req_port.ready = advance;

   assign vld_in = {vld_ff[apr_pkg::PIPE_DEPTH-2:0], req_port.valid};

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (advance) begin
         vld_ff <= vld_in;
      end
   end

   // Capture the pixel, reordered into lane order.
   always_ff @(posedge clock) begin
      if (advance) begin
         chan0_ff[apr_pkg::LANE_RED]   <= req_port.red_in;
         chan0_ff[apr_pkg::LANE_GREEN] <= req_port.green_in;
         chan0_ff[apr_pkg::LANE_BLUE]  <= req_port.blue_in;
         alpha0_ff                     <= req_port.alpha_in;
      end
   end

   // Reciprocal of alpha is looked up once and shared by all lanes.
   apr_recip u_recip (
      .clock    (clock),
      .advance  (advance),
      .alpha    (req_port.alpha_in),
      .recip_ff (recip0_ff)
   );

   // Clear and opaque pixels pass their colors through untouched.
   assign lane_ctl.advance = advance;
   assign lane_ctl.bypass  = (alpha0_ff == apr_pkg::ALPHA_CLEAR)
                          || (alpha0_ff == apr_pkg::CHAN_MAX);

   for (genvar l = 0; l < apr_pkg::NUM_LANES; l++) begin : g_lane
      apr_lane u_lane (
         .clock  (clock),
         .ctl    (lane_ctl),
         .chan   (chan0_ff[l]),
         .alpha  (alpha0_ff),
         .recip  (recip0_ff),
         .res_ff (lane_res[l])
      );
   end

   // Delay alpha to line up with the lane outputs.
   always_ff @(posedge clock) begin
      if (advance) begin
         alpha_dly_ff[0] <= alpha0_ff;
         for (int s = 1; s < apr_pkg::LANE_STAGES; s++) begin
            alpha_dly_ff[s] <= alpha_dly_ff[s-1];
         end
      end
   end

   // Merge the lane results into the outgoing word.
   assign rsp_port.valid     = vld_ff[apr_pkg::PIPE_DEPTH-1];
   assign rsp_port.red_out   = lane_res[apr_pkg::LANE_RED];
   assign rsp_port.green_out = lane_res[apr_pkg::LANE_GREEN];
   assign rsp_port.blue_out  = lane_res[apr_pkg::LANE_BLUE];
   assign rsp_port.alpha_out = alpha_dly_ff[apr_pkg::LANE_STAGES-1];

endmodule

@@ rtl/apr_checker.sv @@
// ---------------------------------------------------------------------------
// apr_checker
// Port-level checks of the unpremultiply block, bound to the top level.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module apr_checker (
   input logic              clock,
   input logic              reset,
   input logic              req_valid,
   input logic              req_ready,
   input apr_pkg::chan_type req_blue,
   input apr_pkg::chan_type req_green,
   input apr_pkg::chan_type req_red,
   input apr_pkg::chan_type req_alpha,
   input logic              rsp_valid,
   input logic              rsp_ready,
   input apr_pkg::chan_type rsp_red,
   input apr_pkg::chan_type rsp_green,
   input apr_pkg::chan_type rsp_blue,
   input apr_pkg::chan_type rsp_alpha
);

   // reset drains the pipe
   property p_reset_flush;
      @(posedge clock) reset |=> !rsp_valid;
   endproperty

   // an opaque word with no stall and no reset reaches the output unchanged,
   // after the input register and the three lane stages
   property p_opaque_latency;
      @(posedge clock) disable iff (reset)
         ($past(req_valid && req_ready && req_alpha == apr_pkg::CHAN_MAX, 4)
          && $past(rsp_ready, 1) && $past(rsp_ready, 2) && $past(rsp_ready, 3)
          && !$past(reset, 1) && !$past(reset, 2) && !$past(reset, 3)
          && !$past(reset, 4))
         |-> (rsp_valid && rsp_alpha == $past(req_alpha, 4)
              && rsp_red == $past(req_red, 4) && rsp_green == $past(req_green, 4)
              && rsp_blue == $past(req_blue, 4));
   endproperty

   `APR_ASSERT(a_reset_flush, p_reset_flush, "result valid after reset")
   `APR_ASSERT(a_opaque_latency, p_opaque_latency, "opaque word not passed in 3 cycles")
   `APR_ASSERT_CLK(a_empty_ready, clock, reset, !rsp_valid |-> req_ready, "stalled while empty")
   `APR_ASSERT_CLK(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready |=> rsp_valid, "result dropped")

endmodule

bind argb_premultiplied_to_rgba apr_checker u_apr_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_port.valid),
   .req_ready (req_port.ready),
   .req_blue  (req_port.blue_in),
   .req_green (req_port.green_in),
   .req_red   (req_port.red_in),
   .req_alpha (req_port.alpha_in),
   .rsp_valid (rsp_port.valid),
   .rsp_ready (rsp_port.ready),
   .rsp_red   (rsp_port.red_out),
   .rsp_green (rsp_port.green_out),
   .rsp_blue  (rsp_port.blue_out),
   .rsp_alpha (rsp_port.alpha_out)
);

@@ verif/tb.sv @@
// ---------------------------------------------------------------------------
// tb
// Self-checking bench for the premultiplied BGRA to straight RGBA converter.
// A driver feeds premultiplied pixel words from a queue, a behavioral
// unpremultiply predictor builds the expected straight word at each accept,
// and a monitor compares every result word field by field in order. Both
// sides idle at random, and the receiver stalls for long stretches so the
// pipeline fills and backs up into the input.
// ---------------------------------------------------------------------------
module tb;

   typedef struct packed {
      apr_pkg::chan_type blue;
      apr_pkg::chan_type green;
      apr_pkg::chan_type red;
      apr_pkg::chan_type alpha;
   } premul_pixel_type;

   typedef struct packed {
      apr_pkg::chan_type red;
      apr_pkg::chan_type green;
      apr_pkg::chan_type blue;
      apr_pkg::chan_type alpha;
   } straight_pixel_type;

   // Random pixel words after the directed list.
   localparam int unsigned RANDOM_PIXELS = 750;
   // Cycles the receiver holds off on a long stall.
   localparam int unsigned LONG_HOLD     = 60;
   // Results between two long stalls.
   localparam int unsigned HOLD_EVERY    = 300;
   // Cycles to watch for stray words once everything is in.
   localparam int unsigned DRAIN_CYCLES  = 12;
   // Cycles without any accept before the run is declared hung.
   localparam int unsigned STALL_LIMIT   = 400;

   logic clock;
   logic reset;

   apr_req_if req_if ();
   apr_rsp_if rsp_if ();

   argb_premultiplied_to_rgba dut (
      .clock    (clock),
      .reset    (reset),
      .req_port (req_if),
      .rsp_port (rsp_if)
   );

   premul_pixel_type   pixel_q[$];     // words not yet offered
   straight_pixel_type straight_q[$];  // predicted results, oldest first
   premul_pixel_type   offered_px;     // word currently on the input
   int unsigned        item_total;
   int unsigned        result_count;
   int unsigned        err_count;
   int unsigned        req_wait;
   int unsigned        rsp_wait;
   int unsigned        stall_cycles;
   bit                 req_steady;
   bit                 rsp_steady;
   bit                 offering;

   always #1 clock = ~clock;

   // Unpremultiply one color channel: rounded division by alpha, saturated.
   // Alpha of zero or full scale leaves the channel as it is.
   function automatic apr_pkg::chan_type unpremul_chan(apr_pkg::chan_type c,
                                                       apr_pkg::chan_type a);
      int unsigned q;
      if (a == apr_pkg::ALPHA_CLEAR || a == apr_pkg::CHAN_MAX)
         return c;
      q = (int'(c) * int'(apr_pkg::CHAN_MAX) + (int'(a) >> 1)) / int'(a);
      if (q > int'(apr_pkg::CHAN_MAX))
         q = int'(apr_pkg::CHAN_MAX);
      return apr_pkg::chan_type'(q);
   endfunction

   function automatic straight_pixel_type unpremultiply(premul_pixel_type p);
      straight_pixel_type s;
      s.red   = unpremul_chan(p.red, p.alpha);
      s.green = unpremul_chan(p.green, p.alpha);
      s.blue  = unpremul_chan(p.blue, p.alpha);
      s.alpha = p.alpha;
      return s;
   endfunction

   // Idle cycles before the next word; zero throughout a steady stretch.
   function automatic int unsigned draw_wait(bit steady);
      return steady ? 0 : $urandom_range(0, 5);
   endfunction

   // Draw one channel value in 0..hi.
   function automatic apr_pkg::chan_type rand_chan(int unsigned hi);
      return apr_pkg::chan_type'($urandom_range(0, hi));
   endfunction

   task automatic add_pixel(apr_pkg::chan_type b, apr_pkg::chan_type g,
                            apr_pkg::chan_type r, apr_pkg::chan_type a);
      premul_pixel_type p;
      p.blue  = b;
      p.green = g;
      p.red   = r;
      p.alpha = a;
      pixel_q.push_back(p);
   endtask

   task automatic report_mismatch(string msg);
      $display("tb: MISMATCH at %0t: %s", $time, msg);
      err_count++;
   endtask

   // Driver: hold the word until accepted, predict it on accept, then idle
   // for the drawn number of cycles before offering the next one.
   always @(posedge clock) begin
      if (reset) begin
         req_if.valid <= 1'b0;
      end else begin
         offering = req_if.valid;
         if (req_if.valid && req_if.ready) begin
            straight_q.push_back(unpremultiply(offered_px));
            offering = 1'b0;
         end
         if (!offering && pixel_q.size() != 0) begin
            if (req_wait != 0) begin
               req_wait--;
            end else begin
               offered_px = pixel_q.pop_front();
               req_if.blue_in  <= offered_px.blue;
               req_if.green_in <= offered_px.green;
               req_if.red_in   <= offered_px.red;
               req_if.alpha_in <= offered_px.alpha;
               offering = 1'b1;
               // Flip between idling and back-to-back stretches now and then.
               if ($urandom_range(0, 29) == 0)
                  req_steady = !req_steady;
               req_wait = draw_wait(req_steady);
            end
         end
         req_if.valid <= offering;
      end
   end

   // Monitor: check each accepted result word against the oldest prediction,
   // then drop ready for the drawn number of cycles. Every HOLD_EVERY words,
   // hold off long enough for the pipeline to fill and stall the input.
   always @(posedge clock) begin
      if (reset) begin
         rsp_if.ready <= 1'b0;
      end else begin
         if (rsp_if.valid && rsp_if.ready) begin
            if (straight_q.size() == 0) begin
               report_mismatch($sformatf(
                  "result word with nothing pending: r=%02h g=%02h b=%02h a=%02h",
                  rsp_if.red_out, rsp_if.green_out, rsp_if.blue_out, rsp_if.alpha_out));
            end else begin
               straight_pixel_type want;
               want = straight_q.pop_front();
               if (rsp_if.red_out !== want.red)
                  report_mismatch($sformatf("red_out %02h, expected %02h",
                     rsp_if.red_out, want.red));
               if (rsp_if.green_out !== want.green)
                  report_mismatch($sformatf("green_out %02h, expected %02h",
                     rsp_if.green_out, want.green));
               if (rsp_if.blue_out !== want.blue)
                  report_mismatch($sformatf("blue_out %02h, expected %02h",
                     rsp_if.blue_out, want.blue));
               if (rsp_if.alpha_out !== want.alpha)
                  report_mismatch($sformatf("alpha_out %02h, expected %02h",
                     rsp_if.alpha_out, want.alpha));
            end
            result_count++;
            if (result_count % HOLD_EVERY == 0) begin
               rsp_wait = LONG_HOLD;
            end else begin
               if ($urandom_range(0, 29) == 0)
                  rsp_steady = !rsp_steady;
               rsp_wait = draw_wait(rsp_steady);
            end
         end
         if (rsp_wait != 0) begin
            rsp_wait--;
            rsp_if.ready <= 1'b0;
         end else begin
            rsp_if.ready <= 1'b1;
         end
      end
   end

   // Watchdog: restart the count on any accept, give up when it runs out.
   always @(posedge clock) begin
      if (reset || (req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready)) begin
         stall_cycles <= 0;
      end else begin
         stall_cycles <= stall_cycles + 1;
         if (stall_cycles >= STALL_LIMIT) begin
            $display("tb: failure");
            $finish;
         end
      end
   end

   initial begin
      int unsigned       kind;
      apr_pkg::chan_type a;

      clock           = 1'b0;
      reset           = 1'b1;
      req_if.valid    = 1'b0;
      req_if.blue_in  = '0;
      req_if.green_in = '0;
      req_if.red_in   = '0;
      req_if.alpha_in = '0;
      rsp_if.ready    = 1'b0;
      result_count    = 0;
      err_count       = 0;
      req_wait        = 0;
      rsp_wait        = 0;
      stall_cycles    = 0;
      req_steady      = 1'b0;
      rsp_steady      = 1'b0;

      // Directed words: transparent and opaque pass-through, saturation when
      // a color exceeds alpha, rounding edges, and distinct channels so any
      // swap of lanes shows up.
      add_pixel(8'h00, 8'h00, 8'h00, 8'h00);
      add_pixel(8'hFF, 8'h80, 8'h01, 8'h00);
      add_pixel(8'hFF, 8'hFF, 8'hFF, 8'hFF);
      add_pixel(8'h00, 8'h00, 8'h00, 8'hFF);
      add_pixel(8'h12, 8'hA5, 8'h5A, 8'hFF);
      add_pixel(8'h01, 8'h00, 8'hFF, 8'h01);
      add_pixel(8'h00, 8'h01, 8'h02, 8'h01);
      add_pixel(8'h01, 8'h02, 8'h01, 8'h02);
      add_pixel(8'h01, 8'h02, 8'h03, 8'h03);
      add_pixel(8'hFE, 8'hFD, 8'hFF, 8'hFE);
      add_pixel(8'h00, 8'h7F, 8'hFE, 8'hFE);
      add_pixel(8'h40, 8'h80, 8'h81, 8'h80);
      add_pixel(8'h3F, 8'h41, 8'h20, 8'h80);
      add_pixel(8'h0A, 8'h14, 8'h1E, 8'h28);
      add_pixel(8'h55, 8'hAA, 8'hFF, 8'h7F);
      add_pixel(8'hAA, 8'h55, 8'h00, 8'hAA);
      add_pixel(8'hFF, 8'hFF, 8'hFF, 8'h01);
      add_pixel(8'h01, 8'h01, 8'h01, 8'hFE);

      // Random words: mostly well-formed premultiplied pixels, some at the
      // alpha extremes, the rest fully random including colors above alpha.
      repeat (RANDOM_PIXELS) begin
         kind = $urandom_range(0, 9);
         if (kind < 6) begin
            a = apr_pkg::chan_type'($urandom_range(1, 254));
            add_pixel(rand_chan(a), rand_chan(a), rand_chan(a), a);
         end else if (kind < 8) begin
            case ($urandom_range(0, 3))
               0: a = 8'h00;
               1: a = 8'h01;
               2: a = 8'hFE;
               default: a = 8'hFF;
            endcase
            add_pixel(rand_chan(255), rand_chan(255), rand_chan(255), a);
         end else begin
            add_pixel(rand_chan(255), rand_chan(255), rand_chan(255), rand_chan(255));
         end
      end
      item_total = pixel_q.size();

      repeat (12) @(posedge clock);
      reset <= 1'b0;

      // Advance until every word has come back, then watch for stray words.
      while (result_count < item_total)
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (straight_q.size() != 0)
         report_mismatch($sformatf("%0d predicted words never arrived", straight_q.size()));

      if (err_count == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end

endmodule

@@ sim.f @@
+incdir+rtl
rtl/apr_pkg.sv
rtl/apr_if.sv
rtl/apr_recip.sv
rtl/apr_lane.sv
rtl/argb_premultiplied_to_rgba.sv
rtl/apr_checker.sv
verif/tb.sv
